/* src/dbd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbd_pkg - shared definitions for the detection box decoder
// Field widths, register indexes and the class pick word.
// ----------------------------------------------------------------------------
package dbd_pkg;

	localparam int NumClassesDef = 8;
	localparam int ScoreMax      = 8;   // score ports on the top level

	localparam int CoordW  = 16;        // Q12.4 centre
	localparam int SizeW   = 15;        // Q11.4 width / height
	localparam int ScoreW  = 16;        // Q1.15
	localparam int ScaleW  = 16;        // Q4.12
	localparam int PadW    = 11;
	localparam int FrameW  = 13;
	localparam int PixW    = 12;        // frame pixel coordinate
	localparam int ClassW  = 3;
	localparam int CfgIdxW = 3;
	localparam int CfgDatW = 16;

	// corner in 1/32 model pixel, and after scaling (2^-17 frame pixel)
	localparam int DiffW = 19;
	localparam int ProdW = DiffW + ScaleW;
	localparam int FracW = 17;

	typedef enum logic [CfgIdxW-1:0] {
		REG_SCORE_THRESHOLD = 3'd0,
		REG_INVERSE_SCALE   = 3'd1,
		REG_PAD_LEFT        = 3'd2,
		REG_PAD_TOP         = 3'd3,
		REG_FRAME_WIDTH     = 3'd4,
		REG_FRAME_HEIGHT    = 3'd5
	} cfg_reg_t;

	// outcome of the class score search
	typedef struct packed {
		logic              keep;
		logic [ClassW-1:0] idx;
		logic [ScoreW-1:0] score;
	} pick_t;

endpackage

/* src/dbd_score_select.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbd_score_select - class score search
// Finds the first strictly largest score and checks it against the threshold.
// ----------------------------------------------------------------------------
module dbd_score_select import dbd_pkg::*; #(
	parameter int NUM_CLASSES = NumClassesDef
) (
	input  logic              clk,
	input  logic [ScoreW-1:0] scores [ScoreMax],
	input  logic [ScoreW-1:0] threshold,
	output pick_t             pick_s1
);

	pick_t pick_d;

	always_comb begin
		logic              found;
		logic [ScoreW-1:0] best;
		logic [ClassW-1:0] idx;
		found = 1'b0;
		best  = '0;
		idx   = '0;
		// strict compare keeps the lowest index on a tie; only the score ports exist
		for (int i = 0; i < NUM_CLASSES && i < ScoreMax; i++) begin
			if (scores[i] > best) begin
				best  = scores[i];
				idx   = ClassW'(i);
				found = 1'b1;
			end
		end
		pick_d.keep  = found && (best >= threshold);
		pick_d.idx   = idx;
		pick_d.score = best;
	end

	always_ff @(posedge clk) begin
		pick_s1 <= pick_d;
	end

endmodule

/* src/dbd_corner_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbd_corner_lane - one box corner, model frame to frame pixels
// Removes padding, scales by the inverse letterbox scale, clamps and rounds.
// ----------------------------------------------------------------------------
module dbd_corner_lane import dbd_pkg::*; (
	input  logic                     clk,
	input  logic signed [CoordW-1:0] centre,
	input  logic [SizeW-1:0]         size,
	input  logic                     negate,     // low corner: centre - size
	input  logic [PadW-1:0]          pad,
	input  logic [ScaleW-1:0]        inv_scale,
	input  logic [PixW-1:0]          bound_m1,   // last pixel inside the frame
	output logic [PixW-1:0]          coord_s3
);

	logic signed [DiffW-1:0] diff_d, diff_s1;
	logic signed [ProdW-1:0] prod_s2;
	logic [PixW+FracW-1:0]   hi, clamped, rounded;

	// 2*centre -/+ size - 32*pad, in 1/32 model pixel
	always_comb begin
		logic signed [DiffW-1:0] c2, sz, pd;
		c2 = {{(DiffW-CoordW-1){centre[CoordW-1]}}, centre, 1'b0};
		sz = {{(DiffW-SizeW){1'b0}}, size};
		pd = {{(DiffW-PadW-5){1'b0}}, pad, 5'b0};
		diff_d = negate ? (c2 - sz - pd) : (c2 + sz - pd);
	end

	always_ff @(posedge clk) begin
		diff_s1 <= diff_d;
		prod_s2 <= diff_s1 * $signed({1'b0, inv_scale});
	end

	// clamp to [0, bound-1] and round half up
	assign hi = {bound_m1, {FracW{1'b0}}};

	always_comb begin
		if (prod_s2[ProdW-1])
			clamped = '0;
		else if (prod_s2[ProdW-2:0] > {{(ProdW-1-PixW-FracW){1'b0}}, hi})
			clamped = hi;
		else
			clamped = prod_s2[PixW+FracW-1:0];
		rounded = clamped + {{PixW{1'b0}}, 1'b1, {(FracW-1){1'b0}}};
	end

	always_ff @(posedge clk) begin
		coord_s3 <= rounded[PixW+FracW-1:FracW];
	end

endmodule

/* src/detection_box_decoder_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// detection_box_decoder_unit - detector prediction to frame box
// Picks the winning class, maps the four corners out of the letterboxed frame
// in parallel lanes and merges them into one box word, or drops the item.
// ----------------------------------------------------------------------------
//
//  channel   handshake            payload
//  -------   -------------------  ---------------------------------------------
//  input     start, busy          centre_x/y, box_width_in/height_in, score_0..7
//  result    done (strobe)        box_left/top, box_width_out/height_out,
//                                 class_index, best_score
//  config    cfg_we               cfg_index, cfg_data
//
//  A word is taken every cycle while busy is low; its result, if any, strobes
//  on done after three lane stages (pad removal, multiply, clamp/round) and
//  the merge register. The 19x17 multiply in each corner lane sets the stage
//  split. busy is high only while arst_n is asserted and for the first cycle
//  after release. Results cannot be stalled; a dropped word leaves no strobe.
//
module detection_box_decoder_unit import dbd_pkg::*; #(
	parameter int NUM_CLASSES = NumClassesDef
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// input words
	input  logic                     start,
	output logic                     busy,
	input  logic signed [CoordW-1:0] centre_x,
	input  logic signed [CoordW-1:0] centre_y,
	input  logic [SizeW-1:0]         box_width_in,
	input  logic [SizeW-1:0]         box_height_in,
	input  logic [ScoreW-1:0]        score_0,
	input  logic [ScoreW-1:0]        score_1,
	input  logic [ScoreW-1:0]        score_2,
	input  logic [ScoreW-1:0]        score_3,
	input  logic [ScoreW-1:0]        score_4,
	input  logic [ScoreW-1:0]        score_5,
	input  logic [ScoreW-1:0]        score_6,
	input  logic [ScoreW-1:0]        score_7,
	// results
	output logic                     done,
	output logic [PixW-1:0]          box_left,
	output logic [PixW-1:0]          box_top,
	output logic [PixW-1:0]          box_width_out,
	output logic [PixW-1:0]          box_height_out,
	output logic [ClassW-1:0]        class_index,
	output logic [ScoreW-1:0]        best_score,
	// configuration
	input  logic                     cfg_we,
	input  logic [CfgIdxW-1:0]       cfg_index,
	input  logic [CfgDatW-1:0]       cfg_data
);

	// ---------------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------------
	logic [ScoreW-1:0] score_threshold_q;
	logic [ScaleW-1:0] inverse_scale_q;
	logic [PadW-1:0]   pad_left_q, pad_top_q;
	logic [FrameW-1:0] frame_width_q, frame_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			score_threshold_q <= ScoreW'(27853);
			inverse_scale_q   <= ScaleW'(4096);
			pad_left_q        <= '0;
			pad_top_q         <= '0;
			frame_width_q     <= FrameW'(640);
			frame_height_q    <= FrameW'(640);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SCORE_THRESHOLD: score_threshold_q <= cfg_data;
				REG_INVERSE_SCALE:   inverse_scale_q   <= cfg_data;
				REG_PAD_LEFT:        pad_left_q        <= cfg_data[PadW-1:0];
				REG_PAD_TOP:         pad_top_q         <= cfg_data[PadW-1:0];
				REG_FRAME_WIDTH:     frame_width_q     <= cfg_data[FrameW-1:0];
				REG_FRAME_HEIGHT:    frame_height_q    <= cfg_data[FrameW-1:0];
				default: ;   // unused indexes are ignored
			endcase
		end
	end

	// Last pixel of the frame: a zero bound acts as 1, anything past 4096 as 4096
	logic [PixW-1:0] width_m1, height_m1;

	always_comb begin
		logic [FrameW-1:0] wm, hm;
		wm = frame_width_q - 1'b1;
		hm = frame_height_q - 1'b1;
		if (frame_width_q == '0)
			width_m1 = '0;
		else if (frame_width_q[FrameW-1] && (frame_width_q[FrameW-2:0] != '0))
			width_m1 = '1;
		else
			width_m1 = wm[PixW-1:0];
		if (frame_height_q == '0)
			height_m1 = '0;
		else if (frame_height_q[FrameW-1] && (frame_height_q[FrameW-2:0] != '0))
			height_m1 = '1;
		else
			height_m1 = hm[PixW-1:0];
	end

	// ---------------------------------------------------------------------
	// Word tracking: no back-pressure, so a plain valid shift line
	// ---------------------------------------------------------------------
	logic busy_q;
	logic valid_s1, valid_s2, valid_s3;
	logic accept;

	assign accept = start && !busy_q;
	assign busy   = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b1;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			busy_q   <= 1'b0;
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// ---------------------------------------------------------------------
	// Class pick, then carried alongside the corner lanes
	// ---------------------------------------------------------------------
	logic [ScoreW-1:0] scores [ScoreMax];
	pick_t             pick_s1, pick_s2, pick_s3;

	assign scores[0] = score_0;
	assign scores[1] = score_1;
	assign scores[2] = score_2;
	assign scores[3] = score_3;
	assign scores[4] = score_4;
	assign scores[5] = score_5;
	assign scores[6] = score_6;
	assign scores[7] = score_7;

	dbd_score_select #(
		.NUM_CLASSES (NUM_CLASSES)
	) u_select (
		.clk       (clk),
		.scores    (scores),
		.threshold (score_threshold_q),
		.pick_s1   (pick_s1)
	);

	always_ff @(posedge clk) begin
		pick_s2 <= pick_s1;
		pick_s3 <= pick_s2;
	end

	// ---------------------------------------------------------------------
	// Four corner lanes: left, right, top, bottom
	// ---------------------------------------------------------------------
	logic [PixW-1:0] left_s3, right_s3, top_s3, bottom_s3;

	dbd_corner_lane u_left (
		.clk       (clk),
		.centre    (centre_x),
		.size      (box_width_in),
		.negate    (1'b1),
		.pad       (pad_left_q),
		.inv_scale (inverse_scale_q),
		.bound_m1  (width_m1),
		.coord_s3  (left_s3)
	);

	dbd_corner_lane u_right (
		.clk       (clk),
		.centre    (centre_x),
		.size      (box_width_in),
		.negate    (1'b0),
		.pad       (pad_left_q),
		.inv_scale (inverse_scale_q),
		.bound_m1  (width_m1),
		.coord_s3  (right_s3)
	);

	dbd_corner_lane u_top (
		.clk       (clk),
		.centre    (centre_y),
		.size      (box_height_in),
		.negate    (1'b1),
		.pad       (pad_top_q),
		.inv_scale (inverse_scale_q),
		.bound_m1  (height_m1),
		.coord_s3  (top_s3)
	);

	dbd_corner_lane u_bottom (
		.clk       (clk),
		.centre    (centre_y),
		.size      (box_height_in),
		.negate    (1'b0),
		.pad       (pad_top_q),
		.inv_scale (inverse_scale_q),
		.bound_m1  (height_m1),
		.coord_s3  (bottom_s3)
	);

	// ---------------------------------------------------------------------
	// Merge: drop low scores and empty boxes, register the result word
	// ---------------------------------------------------------------------
	logic emit;
	logic done_q;
	logic [PixW-1:0]   left_q, top_q, width_q, height_q;
	logic [ClassW-1:0] class_q;
	logic [ScoreW-1:0] score_q;

	assign emit = valid_s3 && pick_s3.keep && (right_s3 > left_s3) && (bottom_s3 > top_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= emit;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			left_q   <= left_s3;
			top_q    <= top_s3;
			width_q  <= right_s3 - left_s3;
			height_q <= bottom_s3 - top_s3;
			class_q  <= pick_s3.idx;
			score_q  <= pick_s3.score;
		end
	end

	assign done           = done_q;
	assign box_left       = left_q;
	assign box_top        = top_q;
	assign box_width_out  = width_q;
	assign box_height_out = height_q;
	assign class_index    = class_q;
	assign best_score     = score_q;

	// ---------------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------------
`ifndef ASSERT_OFF
	a_no_empty_box: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (box_width_out != '0) && (box_height_out != '0))
		else $error("empty box emitted");

	a_drop_rejected: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && !pick_s3.keep |=> !done)
		else $error("rejected word emitted");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s3 |=> !done)
		else $error("result without a word in flight");

	a_class_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (int'(class_index) < NUM_CLASSES))
		else $error("class index out of range");
`endif

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for detection_box_decoder_unit
// A directed table, then eight register settings with random words. Random
// words and predicted table rows are decoded by a predictor in the bench, and
// each done strobe is checked field by field against the oldest box still due.
// ----------------------------------------------------------------------------
module tb_top;
	import dbd_pkg::*;

	// settle time once nothing is due: four pipe stages plus margin
	localparam int DrainCycles = 8;
	localparam int PhaseWords  = 50;

	// one prediction word as it goes into the block
	typedef struct packed {
		logic signed [CoordW-1:0]        cx;
		logic signed [CoordW-1:0]        cy;
		logic [SizeW-1:0]                bw;
		logic [SizeW-1:0]                bh;
		logic [ScoreMax-1:0][ScoreW-1:0] sc;
	} pred_word_t;

	// one decoded box; field order matches the result port concatenation
	typedef struct packed {
		logic [PixW-1:0]   left;
		logic [PixW-1:0]   top;
		logic [PixW-1:0]   wd;
		logic [PixW-1:0]   ht;
		logic [ClassW-1:0] cls;
		logic [ScoreW-1:0] score;
	} frame_box_t;

	// directed rows: box taken from the predictor, typed-in drop, typed-in box
	typedef enum {ROW_PREDICT, ROW_DROP, ROW_BOX} row_kind_t;

	typedef struct {
		row_kind_t  kind;
		pred_word_t word;
		frame_box_t box;
	} dir_row_t;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic signed [CoordW-1:0] centre_x;
	logic signed [CoordW-1:0] centre_y;
	logic [SizeW-1:0]         box_width_in;
	logic [SizeW-1:0]         box_height_in;
	logic [ScoreW-1:0]        score_0;
	logic [ScoreW-1:0]        score_1;
	logic [ScoreW-1:0]        score_2;
	logic [ScoreW-1:0]        score_3;
	logic [ScoreW-1:0]        score_4;
	logic [ScoreW-1:0]        score_5;
	logic [ScoreW-1:0]        score_6;
	logic [ScoreW-1:0]        score_7;
	logic                     done;
	logic [PixW-1:0]          box_left;
	logic [PixW-1:0]          box_top;
	logic [PixW-1:0]          box_width_out;
	logic [PixW-1:0]          box_height_out;
	logic [ClassW-1:0]        class_index;
	logic [ScoreW-1:0]        best_score;
	logic                     cfg_we;
	logic [CfgIdxW-1:0]       cfg_index;
	logic [CfgDatW-1:0]       cfg_data;

	// bench copy of the register file, at register widths
	logic [ScoreW-1:0] thr_q;
	logic [ScaleW-1:0] inv_q;
	logic [PadW-1:0]   pad_l_q;
	logic [PadW-1:0]   pad_t_q;
	logic [FrameW-1:0] fw_q;
	logic [FrameW-1:0] fh_q;

	frame_box_t boxes_due [$];   // expected boxes, oldest first
	dir_row_t   dir_rows [$];
	int         box_errors;
	int         gap_pct;         // chance in 100 that the sender idles a cycle

	detection_box_decoder_unit u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.centre_x       (centre_x),
		.centre_y       (centre_y),
		.box_width_in   (box_width_in),
		.box_height_in  (box_height_in),
		.score_0        (score_0),
		.score_1        (score_1),
		.score_2        (score_2),
		.score_3        (score_3),
		.score_4        (score_4),
		.score_5        (score_5),
		.score_6        (score_6),
		.score_7        (score_7),
		.done           (done),
		.box_left       (box_left),
		.box_top        (box_top),
		.box_width_out  (box_width_out),
		.box_height_out (box_height_out),
		.class_index    (class_index),
		.best_score     (best_score),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always #2 clk = ~clk;

	// ---------------------------------------------------------------- predictor

	// corner in 1/32 model pixel -> frame pixel. Scaling gives 2^-17 px units,
	// then clamp to the frame and round half up. Bound 0 acts as 1, and
	// anything past 4096 as 4096, so results always fit 12 bits.
	function automatic int to_frame_px(longint corner, logic [PadW-1:0] pad,
			logic [FrameW-1:0] bound);
		longint v;
		longint lim;
		longint b;
		v = (corner - longint'(pad) * 32) * longint'(inv_q);
		b = longint'(bound);
		if (b < 1)
			b = 1;
		if (b > 4096)
			b = 4096;
		lim = (b - 1) <<< 17;
		if (v < 0)
			v = 0;
		if (v > lim)
			v = lim;
		return int'((v + (longint'(1) <<< 16)) >>> 17);
	endfunction

	// returns 1 and fills the box when the word survives; first strictly
	// largest score wins, raw unsigned compare, must beat zero and reach thr
	function automatic bit decode_prediction(input pred_word_t p, output frame_box_t b);
		logic [ScoreW-1:0] top_score;
		int                top_idx;
		longint            cx2;
		longint            cy2;
		int                l;
		int                r;
		int                t;
		int                d;
		top_score = '0;
		top_idx   = -1;
		b         = '0;
		for (int c = 0; c < ScoreMax && c < NumClassesDef; c++) begin
			if (p.sc[c] > top_score) begin
				top_score = p.sc[c];
				top_idx   = c;
			end
		end
		if (top_idx < 0 || top_score < thr_q)
			return 1'b0;
		cx2 = 2 * longint'($signed(p.cx));
		cy2 = 2 * longint'($signed(p.cy));
		l = to_frame_px(cx2 - longint'(p.bw), pad_l_q, fw_q);
		r = to_frame_px(cx2 + longint'(p.bw), pad_l_q, fw_q);
		t = to_frame_px(cy2 - longint'(p.bh), pad_t_q, fh_q);
		d = to_frame_px(cy2 + longint'(p.bh), pad_t_q, fh_q);
		if (r <= l || d <= t)
			return 1'b0;
		b.left  = PixW'(l);
		b.top   = PixW'(t);
		b.wd    = PixW'(r - l);
		b.ht    = PixW'(d - t);
		b.cls   = ClassW'(top_idx);
		b.score = top_score;
		return 1'b1;
	endfunction

	// ---------------------------------------------------------------- stimulus

	// all classes at 'rest' except one at 'peak'
	function automatic logic [ScoreMax-1:0][ScoreW-1:0] peak_scores(int cls,
			logic [ScoreW-1:0] peak, logic [ScoreW-1:0] rest);
		logic [ScoreMax-1:0][ScoreW-1:0] s;
		for (int c = 0; c < ScoreMax; c++)
			s[c] = rest;
		s[cls] = peak;
		return s;
	endfunction

	task automatic add_row(row_kind_t kind, int cx, int cy, int bw, int bh,
			logic [ScoreMax-1:0][ScoreW-1:0] sc, frame_box_t box);
		dir_row_t row;
		row.kind    = kind;
		row.word.cx = CoordW'(cx);
		row.word.cy = CoordW'(cy);
		row.word.bw = SizeW'(bw);
		row.word.bh = SizeW'(bh);
		row.word.sc = sc;
		row.box     = box;
		dir_rows.insert(dir_rows.size(), row);
	endtask

	// mostly plausible detections near the frame; a fifth is pure noise over
	// every bit, and some carry all-zero scores or a tie at the top
	function automatic pred_word_t random_word();
		pred_word_t p;
		int         pick;
		logic [ScoreW-1:0] tie;
		pick = $urandom_range(99);
		if (pick < 20) begin
			p.cx = CoordW'($urandom);
			p.cy = CoordW'($urandom);
			p.bw = SizeW'($urandom);
			p.bh = SizeW'($urandom);
			for (int c = 0; c < ScoreMax; c++)
				p.sc[c] = ScoreW'($urandom);
		end else begin
			p.cx = CoordW'(int'($urandom_range(26000)) - 1500);
			p.cy = CoordW'(int'($urandom_range(26000)) - 1500);
			p.bw = SizeW'($urandom_range(6000));
			p.bh = SizeW'($urandom_range(6000));
			for (int c = 0; c < ScoreMax; c++)
				p.sc[c] = ScoreW'($urandom_range(32768));
			if (pick < 30) begin
				p.sc = '0;
			end else if (pick < 42) begin
				tie = ScoreW'($urandom_range(32768, 20000));
				for (int c = 0; c < ScoreMax; c++)
					p.sc[c] = ScoreW'($urandom_range(19999));
				p.sc[$urandom_range(ScoreMax - 1)] = tie;
				p.sc[$urandom_range(ScoreMax - 1)] = tie;
			end
		end
		return p;
	endfunction

	// present one word; returns at the edge that takes it (start high, busy
	// low). start stays high so back-to-back words need no extra step.
	task automatic send_word(input pred_word_t p);
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start         <= 1'b1;
		centre_x      <= p.cx;
		centre_y      <= p.cy;
		box_width_in  <= p.bw;
		box_height_in <= p.bh;
		score_0       <= p.sc[0];
		score_1       <= p.sc[1];
		score_2       <= p.sc[2];
		score_3       <= p.sc[3];
		score_4       <= p.sc[4];
		score_5       <= p.sc[5];
		score_6       <= p.sc[6];
		score_7       <= p.sc[7];
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// one register write; cfg_we is left high for the caller to drop
	task automatic put_reg(cfg_reg_t idx, logic [CfgDatW-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			REG_SCORE_THRESHOLD: thr_q   = val;
			REG_INVERSE_SCALE:   inv_q   = val;
			REG_PAD_LEFT:        pad_l_q = val[PadW-1:0];
			REG_PAD_TOP:         pad_t_q = val[PadW-1:0];
			REG_FRAME_WIDTH:     fw_q    = val[FrameW-1:0];
			REG_FRAME_HEIGHT:    fh_q    = val[FrameW-1:0];
			default: ;
		endcase
	endtask

	task automatic set_regs(int thr, int inv, int pl, int pt, int fw, int fh);
		put_reg(REG_SCORE_THRESHOLD, CfgDatW'(thr));
		put_reg(REG_INVERSE_SCALE,   CfgDatW'(inv));
		put_reg(REG_PAD_LEFT,        CfgDatW'(pl));
		put_reg(REG_PAD_TOP,         CfgDatW'(pt));
		put_reg(REG_FRAME_WIDTH,     CfgDatW'(fw));
		put_reg(REG_FRAME_HEIGHT,    CfgDatW'(fh));
		cfg_we <= 1'b0;
	endtask

	// idle point: every due box has come back, and a dropped word still in
	// the pipe has had time to fall out
	task automatic settle();
		while (boxes_due.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	// ---------------------------------------------------------------- checking

	always @(posedge clk) begin : result_check
		frame_box_t got;
		frame_box_t want;
		logic       bad;
		if (arst_n && done) begin
			got = {box_left, box_top, box_width_out, box_height_out, class_index,
				best_score};
			if (boxes_due.size() == 0) begin
				want = '0;
				bad  = 1'b1;
			end else begin
				want = boxes_due.pop_front();
				bad  = (got.left !== want.left) || (got.top !== want.top) ||
					(got.wd !== want.wd) || (got.ht !== want.ht) ||
					(got.cls !== want.cls) || (got.score !== want.score);
			end
			if (bad) begin
				box_errors++;
				if (box_errors <= 10) begin
					$display("%0t box mismatch%s: want l%0d t%0d w%0d h%0d c%0d s%0d",
						$realtime,
						(boxes_due.size() == 0 && want == '0) ? " (nothing due)" : "",
						want.left, want.top, want.wd, want.ht, want.cls, want.score);
					$display("    got l%0d t%0d w%0d h%0d c%0d s%0d",
						got.left, got.top, got.wd, got.ht, got.cls, got.score);
				end
			end
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin : run
		frame_box_t fb;
		pred_word_t p;
		clk           = 1'b0;
		arst_n        = 1'b0;
		start         = 1'b0;
		centre_x      = '0;
		centre_y      = '0;
		box_width_in  = '0;
		box_height_in = '0;
		score_0       = '0;
		score_1       = '0;
		score_2       = '0;
		score_3       = '0;
		score_4       = '0;
		score_5       = '0;
		score_6       = '0;
		score_7       = '0;
		cfg_we        = 1'b0;
		cfg_index     = REG_SCORE_THRESHOLD;
		cfg_data      = '0;
		box_errors    = 0;
		gap_pct       = 16;

		// register values after reset
		thr_q   = 16'd27853;
		inv_q   = 16'd4096;
		pad_l_q = '0;
		pad_t_q = '0;
		fw_q    = 13'd640;
		fh_q    = 13'd640;

		// Directed table, reset registers: unit scale, no pad, 640x640 frame.
		// Centre (320,240) px, size 64x32 px maps straight to 288,224 64x32.
		add_row(ROW_BOX, 5120, 3840, 1024, 512, peak_scores(0, 16'd32768, 16'd1000),
			'{288, 224, 64, 32, 0, 32768});
		// all equal: lowest class takes it
		add_row(ROW_BOX, 5120, 3840, 1024, 512, peak_scores(0, 16'd30000, 16'd30000),
			'{288, 224, 64, 32, 0, 30000});
		// tie between classes 3 and 6
		add_row(ROW_BOX, 5120, 3840, 1024, 512,
			{16'd500, 16'd31000, 16'd500, 16'd500, 16'd31000, 16'd500, 16'd500, 16'd500},
			'{288, 224, 64, 32, 3, 31000});
		// no positive score
		add_row(ROW_DROP, 5120, 3840, 1024, 512, peak_scores(0, 16'd0, 16'd0), '0);
		// one short of threshold, then exactly on it
		add_row(ROW_DROP, 5120, 3840, 1024, 512, peak_scores(2, 16'd27852, 16'd100), '0);
		add_row(ROW_BOX, 5120, 3840, 1024, 512, peak_scores(7, 16'd27853, 16'd100),
			'{288, 224, 64, 32, 7, 27853});
		// score past 1.0 compares raw
		add_row(ROW_BOX, 5120, 3840, 1024, 512, peak_scores(5, 16'hFFFF, 16'd32768),
			'{288, 224, 64, 32, 5, 65535});
		// zero size on either axis
		add_row(ROW_DROP, 5120, 3840, 0, 512, peak_scores(1, 16'd32768, 16'd0), '0);
		add_row(ROW_DROP, 5120, 3840, 1024, 0, peak_scores(1, 16'd32768, 16'd0), '0);
		// centre extremes: whole box clamps onto one edge
		add_row(ROW_DROP, -32768, 3840, 1024, 512, peak_scores(0, 16'd32768, 16'd0), '0);
		add_row(ROW_DROP, 32767, 3840, 1024, 512, peak_scores(0, 16'd32768, 16'd0), '0);
		add_row(ROW_DROP, 5120, -32768, 1024, 512, peak_scores(0, 16'd32768, 16'd0), '0);
		add_row(ROW_DROP, 5120, 32767, 1024, 512, peak_scores(0, 16'd32768, 16'd0), '0);
		// widest box covers the frame
		add_row(ROW_BOX, 5120, 3840, 32767, 32767, peak_scores(0, 16'd32768, 16'd0),
			'{0, 0, 639, 639, 0, 32768});
		// corners on exact half pixels round up: 99.5 -> 100, 100.5 -> 101
		add_row(ROW_BOX, 1600, 1600, 16, 16, peak_scores(0, 16'd32768, 16'd0),
			'{100, 100, 1, 1, 0, 32768});
		// half-pixel box rounds to nothing
		add_row(ROW_DROP, 1600, 1600, 8, 8, peak_scores(0, 16'd32768, 16'd0), '0);
		// remaining classes, a box hanging off the left and one off the bottom
		add_row(ROW_PREDICT, -800, 2000, 3200, 900, peak_scores(1, 16'd29000, 16'd28000), '0);
		add_row(ROW_PREDICT, 9000, 10100, 777, 4001, peak_scores(2, 16'd32767, 16'hFFFE & 16'h7FFF), '0);
		add_row(ROW_PREDICT, 123, 9999, 5555, 321, peak_scores(4, 16'hFFFF, 16'hFFFE), '0);
		add_row(ROW_PREDICT, 7777, 4321, 2468, 1357, peak_scores(6, 16'd30001, 16'd30000), '0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);

		foreach (dir_rows[i]) begin
			send_word(dir_rows[i].word);
			case (dir_rows[i].kind)
				ROW_BOX:     boxes_due.insert(boxes_due.size(), dir_rows[i].box);
				ROW_PREDICT: if (decode_prediction(dir_rows[i].word, fb))
					boxes_due.insert(boxes_due.size(), fb);
				default: ;
			endcase
		end
		start <= 1'b0;
		settle();

		// Random phases. Sender idles 16% for three settings, 71% for three,
		// then runs flat out. Extremes: threshold 0 / 1.0 / all ones, scale
		// 0 / 1 / max, pad 0 / 1024 / all ones, frame 0 / 1 / 4096 / past 4096.
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: set_regs(0,     4096,  0,    0,    640,  640);
				1: set_regs(20000, 6144,  80,   0,    1920, 1080);
				2: set_regs(32768, 65535, 2047, 2047, 4096, 4096);
				3: set_regs(10000, 1,     0,    0,    1,    1);
				4: set_regs(65535, 2048,  1024, 1024, 8191, 8191);
				5: set_regs(24000, 0,     16,   16,   0,    0);
				6: set_regs(12000, 3277,  0,    140,  2560, 1440);
				default: set_regs(27853, 8192, 100, 60, 320, 240);
			endcase
			gap_pct = (ph < 3) ? 16 : (ph < 6) ? 71 : 0;
			repeat (PhaseWords) begin
				p = random_word();
				send_word(p);
				if (decode_prediction(p, fb))
					boxes_due.insert(boxes_due.size(), fb);
			end
			start <= 1'b0;
			settle();
		end

		if (box_errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// hard stop if the run hangs
	initial begin : watchdog
		#200000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
